/* src/vbrs_pkg.sv */
// ============================================================================
// vbrs_pkg : shared types and constants of the block request sequencer
// Beat formats, request kinds, action and status codes, queue sizes.
// ============================================================================
package vbrs_pkg;

    // Largest number of ID bytes copied for a get-id request.
    localparam int ID_MAX_BYTES = 20;
    localparam int ID_LEN_W     = $clog2(ID_MAX_BYTES + 1);

    // Field widths.
    localparam int SECTOR_W = 48;
    localparam int LEN_W    = 32;
    localparam int ADDR_W   = 64;
    localparam int HEAD_W   = 16;
    localparam int RTYPE_W  = 32;
    localparam int SEC_SH   = 9;
    localparam int LEN_SEC_W = LEN_W - SEC_SH;

    // Configuration port.
    localparam int CFG_DATA_W = 48;
    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_READ_ONLY = 1'b1;

    // Command queue between the front and the back, a power of two deep.
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    // Result queue inside the back, a power of two deep.
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Header request type codes.
    localparam logic [RTYPE_W-1:0] RT_READ  = 32'd0;
    localparam logic [RTYPE_W-1:0] RT_WRITE = 32'd1;
    localparam logic [RTYPE_W-1:0] RT_FLUSH = 32'd4;
    localparam logic [RTYPE_W-1:0] RT_GETID = 32'd8;

    // Beat command codes.
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DESC   = 1'b1;

    // Action codes.
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_READ   = 3'd1;
    localparam logic [2:0] ACT_WRITE  = 3'd2;
    localparam logic [2:0] ACT_STATUS = 3'd3;
    localparam logic [2:0] ACT_COPYID = 3'd4;

    // Request status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_IOERR  = 2'd1;
    localparam logic [1:0] ST_UNSUPP = 2'd2;

    typedef enum logic [2:0] {
        KIND_READ,
        KIND_WRITE,
        KIND_FLUSH,
        KIND_GETID,
        KIND_UNSUPP
    } t_req_kind;

    typedef struct packed {
        logic                cmd;
        logic [HEAD_W-1:0]   head_index;
        logic [RTYPE_W-1:0]  req_type;
        logic [SECTOR_W-1:0] start_sector;
        logic [LEN_W-1:0]    desc_len;
        logic                desc_writable;
        logic                desc_more;
        logic                desc_fault;
        logic [ADDR_W-1:0]   buffer_addr;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        action;
        logic [ADDR_W-1:0] byte_offset;
        logic [ADDR_W-1:0] target_addr;
        logic [LEN_W-1:0]  xfer_len;
        logic [1:0]        status_byte;
        logic              chain_done;
        logic [HEAD_W-1:0] used_head;
        logic [LEN_W-1:0]  used_len;
    } t_out_item;

    // A beat after classification, as it waits in the command queue.
    typedef struct packed {
        logic                 is_hdr;
        t_req_kind            kind;
        logic [HEAD_W-1:0]    head;
        logic [SECTOR_W-1:0]  ssec;
        logic [LEN_W-1:0]     len;
        logic                 len_is1;
        logic                 len_gt1;
        logic [LEN_SEC_W-1:0] len_sec;
        logic [ID_LEN_W-1:0]  id_len;
        logic                 wr;
        logic                 more;
        logic                 fault;
        logic [ADDR_W-1:0]    addr;
    } t_cls;

endpackage

/* src/vbrs_front.sv */
// ============================================================================
// vbrs_front : beat intake and classification
// Decodes each accepted beat and holds it in a small command queue.
// ============================================================================
module vbrs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  vbrs_pkg::t_in_item i_item,
    output logic              full,
    output logic              o_cls_valid,
    output vbrs_pkg::t_cls    o_cls,
    input  logic              i_cls_take
);
    import vbrs_pkg::*;

    t_cls              r_q [CQ_DEPTH];
    logic [CQ_AW-1:0]  r_wp;
    logic [CQ_AW-1:0]  r_rp;
    logic [CQ_CW-1:0]  r_cnt;
    t_cls              w_cls;
    logic              w_push_ok;
    logic              w_pop_ok;

    always_comb begin
        w_cls.is_hdr  = (i_item.cmd == CMD_HEADER);
        case (i_item.req_type)
            RT_READ:  w_cls.kind = KIND_READ;
            RT_WRITE: w_cls.kind = KIND_WRITE;
            RT_FLUSH: w_cls.kind = KIND_FLUSH;
            RT_GETID: w_cls.kind = KIND_GETID;
            default:  w_cls.kind = KIND_UNSUPP;
        endcase
        w_cls.head    = i_item.head_index;
        w_cls.ssec    = i_item.start_sector;
        w_cls.len     = i_item.desc_len;
        w_cls.len_is1 = (i_item.desc_len == LEN_W'(1));
        w_cls.len_gt1 = (i_item.desc_len > LEN_W'(1));
        w_cls.len_sec = i_item.desc_len[LEN_W-1:SEC_SH];
        w_cls.id_len  = (i_item.desc_len < LEN_W'(ID_MAX_BYTES)) ?
                        i_item.desc_len[ID_LEN_W-1:0] : ID_LEN_W'(ID_MAX_BYTES);
        w_cls.wr      = i_item.desc_writable;
        w_cls.more    = i_item.desc_more;
        w_cls.fault   = i_item.desc_fault;
        w_cls.addr    = i_item.buffer_addr;
    end

    assign full        = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign o_cls_valid = (r_cnt != '0);
    assign o_cls       = r_q[r_rp];
    assign w_push_ok   = push && !full;
    assign w_pop_ok    = i_cls_take && o_cls_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_q[r_wp] <= w_cls;
                r_wp      <= r_wp + CQ_AW'(1);
            end
            if (w_pop_ok) begin
                r_rp <= r_rp + CQ_AW'(1);
            end
            case ({w_push_ok, w_pop_ok})
                2'b10:   r_cnt <= r_cnt + CQ_CW'(1);
                2'b01:   r_cnt <= r_cnt - CQ_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CQ_CW'(CQ_DEPTH))
        else $error("command queue count out of range");

endmodule

/* src/vbrs_back.sv */
// ============================================================================
// vbrs_back : chain sequencer and result queue
// Walks the request chain, issues one action per beat, queues the results.
// ============================================================================
module vbrs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [vbrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_cls_valid,
    input  vbrs_pkg::t_cls                i_cls,
    output logic                          o_cls_take,
    output logic                          empty,
    input  logic                          pop,
    output vbrs_pkg::t_out_item           o_res
);
    import vbrs_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_READ,
        MODE_WRITE,
        MODE_FLUSH,
        MODE_GETID,
        MODE_UNSUPP
    } t_mode;

    t_mode               r_mode,   n_mode;
    logic [SECTOR_W-1:0] r_sector, n_sector;
    logic [1:0]          r_status, n_status;
    logic [LEN_W-1:0]    r_bw,     n_bw;
    logic [HEAD_W-1:0]   r_head,   n_head;
    logic [CFG_DATA_W-1:0] r_cap;
    logic                r_ro;

    t_out_item           r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0]    r_oq_wp;
    logic [OQ_AW-1:0]    r_oq_rp;
    logic [OQ_CW-1:0]    r_oq_cnt;

    t_out_item           w_res;
    logic                w_proc;
    logic                w_pop_ok;
    logic [SECTOR_W+SEC_SH-1:0]   w_here;
    logic [SECTOR_W+SEC_SH:0]     w_end;
    logic                w_in_range;
    logic [SECTOR_W-1:0] w_sec_adv;
    logic                w_done;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? '1 : s[LEN_W-1:0];
    endfunction

    assign w_pop_ok   = pop && !empty;
    assign empty      = (r_oq_cnt == '0);
    assign o_res      = r_oq[r_oq_rp];
    assign o_cls_take = (r_oq_cnt != OQ_CW'(OQ_DEPTH)) || w_pop_ok;
    assign w_proc     = i_cls_valid && o_cls_take;

    // Byte offset of the current sector and the end of this buffer's range.
    assign w_here     = {r_sector, SEC_SH'(0)};
    assign w_end      = {1'b0, w_here} + (SECTOR_W + SEC_SH + 1)'(i_cls.len);
    assign w_in_range = (w_end <= (SECTOR_W + SEC_SH + 1)'(r_cap));
    assign w_sec_adv  = r_sector + SECTOR_W'(i_cls.len_sec);

    always_comb begin
        n_mode   = r_mode;
        n_sector = r_sector;
        n_status = r_status;
        n_bw     = r_bw;
        n_head   = r_head;
        w_done   = 1'b0;
        w_res.action      = ACT_NONE;
        w_res.byte_offset = '0;
        w_res.target_addr = '0;
        w_res.xfer_len    = '0;

        if (i_cls.is_hdr) begin
            if (i_cls.fault) begin
                n_mode = MODE_IDLE;
            end else begin
                n_head   = i_cls.head;
                n_sector = i_cls.ssec;
                n_bw     = '0;
                n_status = ST_OK;
                case (i_cls.kind)
                    KIND_READ:  n_mode = MODE_READ;
                    KIND_WRITE: n_mode = MODE_WRITE;
                    KIND_FLUSH: n_mode = MODE_FLUSH;
                    KIND_GETID: n_mode = MODE_GETID;
                    default: begin
                        n_mode   = MODE_UNSUPP;
                        n_status = ST_UNSUPP;
                    end
                endcase
                if (!i_cls.more) begin
                    w_done = 1'b1;
                    n_mode = MODE_IDLE;
                end
            end
        end else if (r_mode != MODE_IDLE) begin
            if (i_cls.fault) begin
                w_done = 1'b1;
            end else begin
                case (r_mode)
                    MODE_READ: begin
                        if (i_cls.wr) begin
                            if (i_cls.len_is1) begin
                                w_res.action      = ACT_STATUS;
                                w_res.target_addr = i_cls.addr;
                                w_res.xfer_len    = LEN_W'(1);
                                n_bw = sat_add(r_bw, LEN_W'(1));
                            end else begin
                                if (w_in_range) begin
                                    w_res.action      = ACT_READ;
                                    w_res.byte_offset = ADDR_W'(w_here);
                                    w_res.target_addr = i_cls.addr;
                                    w_res.xfer_len    = i_cls.len;
                                end else begin
                                    n_status = ST_IOERR;
                                end
                                n_sector = w_sec_adv;
                                n_bw     = sat_add(r_bw, i_cls.len);
                            end
                        end
                    end
                    MODE_WRITE: begin
                        if (i_cls.wr) begin
                            w_res.action      = ACT_STATUS;
                            w_res.target_addr = i_cls.addr;
                            w_res.xfer_len    = LEN_W'(1);
                            n_bw = sat_add(r_bw, LEN_W'(1));
                        end else if (i_cls.len_gt1) begin
                            if (!r_ro && w_in_range) begin
                                w_res.action      = ACT_WRITE;
                                w_res.byte_offset = ADDR_W'(w_here);
                                w_res.target_addr = i_cls.addr;
                                w_res.xfer_len    = i_cls.len;
                            end else begin
                                n_status = ST_IOERR;
                            end
                            n_sector = w_sec_adv;
                        end
                    end
                    MODE_GETID: begin
                        if (i_cls.wr) begin
                            w_res.target_addr = i_cls.addr;
                            if (i_cls.len_is1) begin
                                w_res.action   = ACT_STATUS;
                                w_res.xfer_len = LEN_W'(1);
                                n_bw = sat_add(r_bw, LEN_W'(1));
                            end else begin
                                w_res.action   = ACT_COPYID;
                                w_res.xfer_len = LEN_W'(i_cls.id_len);
                                n_bw = sat_add(r_bw, LEN_W'(i_cls.id_len));
                            end
                        end
                    end
                    default: begin
                        // Flush and unsupported requests only look for the
                        // status descriptor, which also ends the chain.
                        if (i_cls.wr && i_cls.len_is1) begin
                            w_res.action      = ACT_STATUS;
                            w_res.target_addr = i_cls.addr;
                            w_res.xfer_len    = LEN_W'(1);
                            n_bw   = sat_add(r_bw, LEN_W'(1));
                            w_done = 1'b1;
                        end
                    end
                endcase
                if (!i_cls.more) begin
                    w_done = 1'b1;
                end
            end
            if (w_done) begin
                n_mode = MODE_IDLE;
            end
        end

        w_res.status_byte = n_status;
        w_res.chain_done  = w_done;
        w_res.used_head   = n_head;
        w_res.used_len    = n_bw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_sector <= '0;
            r_status <= ST_OK;
            r_bw     <= '0;
            r_head   <= '0;
            r_cap    <= '0;
            r_ro     <= 1'b0;
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAPACITY:  r_cap <= i_cfg_data;
                    CFG_READ_ONLY: r_ro  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_proc) begin
                r_mode   <= n_mode;
                r_sector <= n_sector;
                r_status <= n_status;
                r_bw     <= n_bw;
                r_head   <= n_head;
                r_oq[r_oq_wp] <= w_res;
                r_oq_wp  <= r_oq_wp + OQ_AW'(1);
            end
            if (w_pop_ok) begin
                r_oq_rp <= r_oq_rp + OQ_AW'(1);
            end
            case ({w_proc, w_pop_ok})
                2'b10:   r_oq_cnt <= r_oq_cnt + OQ_CW'(1);
                2'b01:   r_oq_cnt <= r_oq_cnt - OQ_CW'(1);
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= OQ_CW'(OQ_DEPTH))
        else $error("result queue count out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_res.chain_done |=> r_mode == MODE_IDLE)
        else $error("chain ended but sequencer did not return to idle");

    a_idle_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && !i_cls.is_hdr && (r_mode == MODE_IDLE)
        |-> (w_res.action == ACT_NONE) && !w_res.chain_done)
        else $error("descriptor outside a chain produced an action");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_proc |=> $stable(r_sector) && $stable(r_bw) && $stable(r_head))
        else $error("chain state changed without a beat");

endmodule

/* src/virtio_block_request_sequencer_core.sv */
// A pushed beat is registered in the command queue, its result then in the
// result queue. Throughput: one beat per cycle while the result queue has
// room or is popped; the chain sequencer retires one beat a cycle.
// Reset: synchronous, active low; clears both queues, the chain state and the
// configuration registers. No clearing pass is needed.
// ============================================================================
// virtio_block_request_sequencer_core : block request sequencer top level
// Front classifies descriptor beats, back walks the chain and queues results.
// ============================================================================
module virtio_block_request_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port: index 0 capacity in bytes, index 1 read-only.
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [vbrs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Descriptor beats in.
    input  logic                            push,
    input  vbrs_pkg::t_in_item              i_item,
    output logic                            full,
    // Action beats out.
    output logic                            empty,
    input  logic                            pop,
    output vbrs_pkg::t_out_item             o_res
);
    import vbrs_pkg::*;

    // The front decodes the request type, the length classes (exactly one
    // byte, more than one byte), the sector step and the clipped ID length,
    // and queues the classified beat. The command queue lets the front keep
    // taking beats while the back waits on a full result queue.
    t_cls w_cls;
    logic w_cls_valid;
    logic w_cls_take;

    vbrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_cls_valid (w_cls_valid),
        .o_cls       (w_cls),
        .i_cls_take  (w_cls_take)
    );

    // The back holds the chain state (mode, current sector, status, bytes
    // written and head), the configuration registers, and a two-entry result
    // queue. Each classified beat produces exactly one result beat, so the
    // back takes a beat whenever the result queue has room or is being
    // popped in the same cycle.
    vbrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cls_valid (w_cls_valid),
        .i_cls       (w_cls),
        .o_cls_take  (w_cls_take),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ============================================================================
// testbench : self-checking bench for the block request sequencer
// Drives descriptor beats through the push/full side and pops action beats
// from the empty/pop side. A chain walker inside the bench predicts every
// action beat. A short table of directed beats comes first, followed by random
// request chains under several register settings, with random idle gaps on
// both sides.
// ============================================================================
module testbench;
    import vbrs_pkg::*;

    localparam int HALF_PERIOD       = 6;
    localparam int RESET_CYCLES      = 4;
    localparam int NUM_SETTINGS      = 6;
    localparam int ITEMS_PER_SETTING = 185;
    localparam int SETTLE_CYCLES     = 4;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int RUN_LIMIT_NS      = 5_000_000;
    localparam logic [SECTOR_W-1:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    // Chain walker modes. The package has request kinds but no idle state.
    typedef enum logic [2:0] {
        CH_IDLE,
        CH_READ,
        CH_WRITE,
        CH_FLUSH,
        CH_GETID,
        CH_UNSUPP
    } t_chain_mode;

    typedef enum logic {
        ROW_SETTINGS,
        ROW_BEAT
    } t_row_kind;

    // One row of the directed table: either a register setting or one beat,
    // the latter with an optional hand-written action beat.
    typedef struct {
        t_row_kind       kind;
        logic [47:0]     cap;
        logic            ro;
        t_in_item        beat;
        bit              known;
        t_out_item       res;
    } t_stim_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic                  i_cfg_idx  = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push       = 1'b0;
    t_in_item              i_item     = '0;
    logic                  full;
    logic                  empty;
    logic                  pop        = 1'b0;
    t_out_item             o_res;

    virtio_block_request_sequencer_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .i_item     (i_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 0;
    end

    // ------------------------------------------------------------------------
    // Chain walker: the bench's own copy of the sequencer state and registers.
    // ------------------------------------------------------------------------
    t_chain_mode         walk_mode   = CH_IDLE;
    logic [SECTOR_W-1:0] walk_sector = '0;
    logic [1:0]          walk_status = ST_OK;
    logic [LEN_W-1:0]    guest_bytes = '0;
    logic [HEAD_W-1:0]   walk_head   = '0;
    logic [47:0]         cap_bytes   = '0;
    logic                ro_flag     = 1'b0;

    // Action beats still owed by the block, oldest first.
    t_out_item pending_actions[$];
    t_stim_row directed_rows[$];

    int  mismatches    = 0;
    int  live_beats    = 0;
    int  actions_seen  = 0;
    int  chains_closed = 0;
    int  full_stalls   = 0;
    int  settings_used = 0;
    int  rx_hold_req   = 0;
    bit  tx_smooth     = 1'b0;

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic bit fits_store(logic [63:0] off, logic [31:0] len);
        return (off + {32'd0, len}) <= {16'd0, cap_bytes};
    endfunction

    // The status descriptor: one byte to the guest, counted in the used length.
    function automatic void store_status(inout t_out_item r, input logic [63:0] addr);
        r.action      = ACT_STATUS;
        r.target_addr = addr;
        r.xfer_len    = 32'd1;
        guest_bytes   = sat_add(guest_bytes, 32'd1);
    endfunction

    // Advances the walker by one accepted beat and returns the action beat
    // that the block must answer with.
    function automatic t_out_item next_action(t_in_item it);
        t_out_item   r;
        logic [63:0] here;
        bit          done;
        r    = '0;
        done = 1'b0;
        if (it.cmd == CMD_HEADER) begin
            if (it.desc_fault) begin
                // A header that failed to fetch starts nothing.
                walk_mode = CH_IDLE;
            end else begin
                walk_head   = it.head_index;
                walk_sector = it.start_sector;
                guest_bytes = '0;
                walk_status = ST_OK;
                case (it.req_type)
                    RT_READ:  walk_mode = CH_READ;
                    RT_WRITE: walk_mode = CH_WRITE;
                    RT_FLUSH: walk_mode = CH_FLUSH;
                    RT_GETID: walk_mode = CH_GETID;
                    default: begin
                        walk_mode   = CH_UNSUPP;
                        walk_status = ST_UNSUPP;
                    end
                endcase
                if (!it.desc_more) begin
                    done      = 1'b1;
                    walk_mode = CH_IDLE;
                end
            end
        end else if (walk_mode != CH_IDLE) begin
            if (it.desc_fault) begin
                done = 1'b1;
            end else begin
                here = {7'd0, walk_sector, 9'd0};
                case (walk_mode)
                    CH_READ: begin
                        if (it.desc_writable) begin
                            if (it.desc_len == 32'd1) begin
                                store_status(r, it.buffer_addr);
                            end else begin
                                // A failed range check still advances and counts.
                                if (fits_store(here, it.desc_len)) begin
                                    r.action      = ACT_READ;
                                    r.byte_offset = here;
                                    r.target_addr = it.buffer_addr;
                                    r.xfer_len    = it.desc_len;
                                end else begin
                                    walk_status = ST_IOERR;
                                end
                                walk_sector = walk_sector + {16'd0, it.desc_len >> SEC_SH};
                                guest_bytes = sat_add(guest_bytes, it.desc_len);
                            end
                        end
                    end
                    CH_WRITE: begin
                        if (it.desc_writable) begin
                            store_status(r, it.buffer_addr);
                        end else if (it.desc_len > 32'd1) begin
                            if (!ro_flag && fits_store(here, it.desc_len)) begin
                                r.action      = ACT_WRITE;
                                r.byte_offset = here;
                                r.target_addr = it.buffer_addr;
                                r.xfer_len    = it.desc_len;
                            end else begin
                                walk_status = ST_IOERR;
                            end
                            walk_sector = walk_sector + {16'd0, it.desc_len >> SEC_SH};
                        end
                    end
                    CH_GETID: begin
                        if (it.desc_writable) begin
                            if (it.desc_len == 32'd1) begin
                                store_status(r, it.buffer_addr);
                            end else begin
                                r.action      = ACT_COPYID;
                                r.target_addr = it.buffer_addr;
                                r.xfer_len    = (it.desc_len < ID_MAX_BYTES) ?
                                                it.desc_len : ID_MAX_BYTES;
                                guest_bytes   = sat_add(guest_bytes, r.xfer_len);
                            end
                        end
                    end
                    default: begin
                        // Flush and unsupported only wait for the status byte,
                        // which closes the chain even when more descriptors follow.
                        if (it.desc_writable && it.desc_len == 32'd1) begin
                            store_status(r, it.buffer_addr);
                            done = 1'b1;
                        end
                    end
                endcase
                if (!it.desc_more) done = 1'b1;
            end
            if (done) walk_mode = CH_IDLE;
        end
        r.status_byte = walk_status;
        r.chain_done  = done;
        r.used_head   = walk_head;
        r.used_len    = guest_bytes;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] t;
        t = rand64();
        return t[47:0];
    endfunction

    function automatic bit coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // A beat with every field random; chains overwrite what they care about.
    function automatic t_in_item noise_beat();
        t_in_item    b;
        logic [63:0] a;
        logic [63:0] c;
        a = rand64();
        c = rand64();
        b.cmd           = a[63];
        b.head_index    = a[15:0];
        b.req_type      = a[47:16];
        b.start_sector  = c[47:0];
        b.desc_len      = c[63:32];
        b.desc_writable = a[48];
        b.desc_more     = a[49];
        b.desc_fault    = a[50];
        b.buffer_addr   = rand64();
        return b;
    endfunction

    function automatic logic [31:0] pick_len();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1;
            2, 3, 4: begin
                k = $urandom_range(1, 8);
                return k << SEC_SH;
            end
            5, 6:    return $urandom_range(2, 1000);
            7:       return $urandom_range(2, 40);
            8:       return $urandom;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_rtype();
        int v;
        v = $urandom_range(0, 19);
        if (v < 6)  return RT_READ;
        if (v < 12) return RT_WRITE;
        if (v < 14) return RT_FLUSH;
        if (v < 17) return RT_GETID;
        if (v < 19) return $urandom;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [47:0] pick_sector();
        int          v;
        logic [47:0] back;
        v = $urandom_range(0, 19);
        if (v < 14) return {16'd0, 32'($urandom_range(0, 2048))};
        if (v < 17) return rand48();
        back = {16'd0, 32'($urandom_range(0, 64))};
        return MAX48 - back;
    endfunction

    function automatic int pick_gap();
        int v;
        if (tx_smooth) return 0;
        v = $urandom_range(0, 99);
        if (v < 55) return 0;
        if (v < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_rx_stall();
        if (coin(90)) return $urandom_range(0, 2);
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Offers one beat after a random gap and holds it until the block takes it.
    // A known action beat replaces the prediction, but the walker still runs so
    // that its state follows the block.
    task automatic send_beat(t_in_item it, bit known, t_out_item known_res);
        int        gap;
        t_out_item r;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        if (!(it.cmd == CMD_DESC && walk_mode == CH_IDLE)) live_beats++;
        r = next_action(it);
        if (known) r = known_res;
        pending_actions.push_back(r);
    endtask

    // Stops offering, waits for every owed action beat, then lets the block settle.
    task automatic settle();
        push <= 1'b0;
        while (pending_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers; only called while the block is idle.
    task automatic apply_settings(logic [47:0] cap, logic ro);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CAPACITY;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_READ_ONLY;
        i_cfg_data <= {47'd0, ro};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_bytes  = cap;
        ro_flag    = ro;
        settings_used++;
    endtask

    // One random request chain, or now and then a lone noise beat. Most chains
    // are well formed; some carry faults, early ends or a missing status byte.
    task automatic send_chain();
        t_in_item    b;
        logic [31:0] rt;
        bit          want_wr;
        int          n;
        tx_smooth = coin(10);
        if (coin(8)) begin
            send_beat(noise_beat(), 1'b0, '0);
            return;
        end
        rt = pick_rtype();
        b  = noise_beat();
        b.cmd           = CMD_HEADER;
        b.req_type      = rt;
        b.start_sector  = pick_sector();
        b.desc_fault    = coin(2);
        b.desc_more     = coin(95);
        send_beat(b, 1'b0, '0);
        if (rt == RT_READ || rt == RT_GETID) want_wr = 1'b1;
        else if (rt == RT_WRITE)             want_wr = 1'b0;
        else                                 want_wr = coin(50);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            b = noise_beat();
            b.cmd           = CMD_DESC;
            b.desc_len      = pick_len();
            b.desc_writable = coin(85) ? want_wr : coin(50);
            b.desc_more     = coin(95);
            b.desc_fault    = coin(3);
            send_beat(b, 1'b0, '0);
        end
        if (coin(92)) begin
            b = noise_beat();
            b.cmd           = CMD_DESC;
            b.desc_len      = 32'd1;
            b.desc_writable = 1'b1;
            b.desc_more     = coin(10);
            b.desc_fault    = 1'b0;
            send_beat(b, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table.
    // ------------------------------------------------------------------------
    function automatic t_in_item mk_hdr(logic [15:0] head, logic [31:0] rtype,
                                        logic [47:0] sec, logic more, logic fault);
        t_in_item b;
        b = '0;
        b.cmd           = CMD_HEADER;
        b.head_index    = head;
        b.req_type      = rtype;
        b.start_sector  = sec;
        b.desc_more     = more;
        b.desc_fault    = fault;
        return b;
    endfunction

    function automatic t_in_item mk_desc(logic [31:0] len, logic wr, logic more,
                                         logic fault, logic [63:0] addr);
        t_in_item b;
        b = '0;
        b.cmd           = CMD_DESC;
        b.desc_len      = len;
        b.desc_writable = wr;
        b.desc_more     = more;
        b.desc_fault    = fault;
        b.buffer_addr   = addr;
        return b;
    endfunction

    // Action beat with no transfer: only status and used-ring fields set.
    function automatic t_out_item mk_quiet(logic [1:0] st, logic done,
                                           logic [15:0] head);
        t_out_item r;
        r = '0;
        r.status_byte = st;
        r.chain_done  = done;
        r.used_head   = head;
        return r;
    endfunction

    function automatic void add_settings(logic [47:0] cap, logic ro);
        t_stim_row row;
        row = '{kind: ROW_SETTINGS, cap: cap, ro: ro, beat: '0, known: 1'b0, res: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_beat(t_in_item b, bit known, t_out_item res);
        t_stim_row row;
        row = '{kind: ROW_BEAT, cap: '0, ro: 1'b0, beat: b, known: known, res: res};
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed();
        add_settings(48'h1_0000, 1'b0);
        // A descriptor with no open chain does nothing; state is still reset.
        add_beat(mk_desc(32'h1000, 1'b1, 1'b1, 1'b0, 64'h1234), 1'b1,
                 mk_quiet(ST_OK, 1'b0, 16'h0000));
        // A header that failed to fetch leaves the block idle.
        add_beat(mk_hdr(16'h1234, RT_READ, 48'd5, 1'b1, 1'b1), 1'b1,
                 mk_quiet(ST_OK, 1'b0, 16'h0000));
        // A header without a next descriptor closes its chain at once.
        add_beat(mk_hdr(16'hFFFF, RT_READ, MAX48, 1'b0, 1'b0), 1'b1,
                 mk_quiet(ST_OK, 1'b1, 16'hFFFF));
        // Plain read chain, including a zero-length buffer.
        add_beat(mk_hdr(16'h0001, RT_READ, 48'd0, 1'b1, 1'b0), 1'b0, '0);
        add_beat(mk_desc(32'd4096, 1'b1, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF), 1'b0, '0);
        add_beat(mk_desc(32'd0, 1'b1, 1'b1, 1'b0, 64'h0), 1'b0, '0);
        add_beat(mk_desc(32'd1, 1'b1, 1'b0, 1'b0, 64'h8000), 1'b0, '0);
        // Plain write chain.
        add_beat(mk_hdr(16'h0002, RT_WRITE, 48'd2, 1'b1, 1'b0), 1'b0, '0);
        add_beat(mk_desc(32'd512, 1'b0, 1'b1, 1'b0, 64'h1000), 1'b0, '0);
        add_beat(mk_desc(32'd1, 1'b1, 1'b0, 1'b0, 64'h2000), 1'b0, '0);
        // Writes fail when the store is read-only.
        add_settings(48'h1_0000, 1'b1);
        add_beat(mk_hdr(16'h0003, RT_WRITE, 48'd0, 1'b1, 1'b0), 1'b0, '0);
        add_beat(mk_desc(32'd1024, 1'b0, 1'b1, 1'b0, 64'h3000), 1'b0, '0);
        add_beat(mk_desc(32'd1, 1'b1, 1'b0, 1'b0, 64'h4000), 1'b0, '0);
        add_settings(MAX48, 1'b0);
        // Flush: only the status byte acts, and it ends the chain.
        add_beat(mk_hdr(16'h0004, RT_FLUSH, 48'd0, 1'b1, 1'b0), 1'b0, '0);
        add_beat(mk_desc(32'd100, 1'b1, 1'b1, 1'b0, 64'h5000), 1'b0, '0);
        add_beat(mk_desc(32'd1, 1'b1, 1'b1, 1'b0, 64'h6000), 1'b0, '0);
        // Get-id copies at most the ID length.
        add_beat(mk_hdr(16'h0005, RT_GETID, 48'd0, 1'b1, 1'b0), 1'b0, '0);
        add_beat(mk_desc(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 64'h7000), 1'b0, '0);
        add_beat(mk_desc(32'd1, 1'b1, 1'b0, 1'b0, 64'h7100), 1'b0, '0);
        // Unsupported type, then a descriptor fault closes the chain.
        add_beat(mk_hdr(16'hABCD, 32'hFFFF_FFFF, 48'd0, 1'b1, 1'b0), 1'b1,
                 mk_quiet(ST_UNSUPP, 1'b0, 16'hABCD));
        add_beat(mk_desc(32'd1, 1'b1, 1'b1, 1'b1, 64'h0), 1'b1,
                 mk_quiet(ST_UNSUPP, 1'b1, 16'hABCD));
        // A new header drops the open chain without a used entry.
        add_beat(mk_hdr(16'h0007, RT_READ, 48'd0, 1'b1, 1'b0), 1'b0, '0);
        add_beat(mk_hdr(16'h0008, RT_WRITE, 48'd0, 1'b1, 1'b0), 1'b0, '0);
        add_beat(mk_desc(32'd512, 1'b0, 1'b0, 1'b0, 64'h9000), 1'b0, '0);
        // Top sector: range fails, sector wraps, used length saturates.
        add_beat(mk_hdr(16'h0009, RT_READ, MAX48, 1'b1, 1'b0), 1'b0, '0);
        add_beat(mk_desc(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 64'hA000), 1'b0, '0);
        add_beat(mk_desc(32'd1, 1'b1, 1'b0, 1'b0, 64'hB000), 1'b0, '0);
        // With no capacity every nonzero range fails.
        add_settings(48'd0, 1'b0);
        add_beat(mk_hdr(16'h000A, RT_READ, 48'd0, 1'b1, 1'b0), 1'b0, '0);
        add_beat(mk_desc(32'd512, 1'b1, 1'b0, 1'b0, 64'hC000), 1'b0, '0);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random pop pattern and the scoreboard check.
    // ------------------------------------------------------------------------
    function automatic void field_check(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_action(t_out_item got);
        t_out_item want;
        if (pending_actions.size() == 0) begin
            $error("action beat with nothing expected: %p", got);
            mismatches++;
            return;
        end
        want = pending_actions.pop_front();
        field_check("action",      {61'd0, want.action},      {61'd0, got.action});
        field_check("byte_offset", want.byte_offset,          got.byte_offset);
        field_check("target_addr", want.target_addr,          got.target_addr);
        field_check("xfer_len",    {32'd0, want.xfer_len},    {32'd0, got.xfer_len});
        field_check("status_byte", {62'd0, want.status_byte}, {62'd0, got.status_byte});
        field_check("chain_done",  {63'd0, want.chain_done},  {63'd0, got.chain_done});
        field_check("used_head",   {48'd0, want.used_head},   {48'd0, got.used_head});
        field_check("used_len",    {32'd0, want.used_len},    {32'd0, got.used_len});
        actions_seen++;
        if (want.chain_done) chains_closed++;
    endfunction

    // The sink pops at random. A long hold requested by the main flow is
    // counted down here while the sender keeps pushing, so the queues fill.
    initial begin : action_sink
        int  stall;
        bit  rx_smooth;
        stall     = 0;
        rx_smooth = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) check_action(o_res);
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else if (rx_smooth || coin(65)) begin
                pop <= 1'b1;
            end else begin
                pop <= 1'b0;
                stall = pick_rx_stall();
            end
            if ($urandom_range(0, 199) == 0) rx_smooth = !rx_smooth;
        end
    end

    // ------------------------------------------------------------------------
    // Main flow.
    // ------------------------------------------------------------------------
    initial begin : main_flow
        logic [47:0] cap;
        logic        ro;
        int          goal;
        build_directed();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_SETTINGS) begin
                settle();
                apply_settings(directed_rows[i].cap, directed_rows[i].ro);
            end else begin
                send_beat(directed_rows[i].beat, directed_rows[i].known,
                          directed_rows[i].res);
            end
        end

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            settle();
            case (p)
                0: begin cap = MAX48;  ro = 1'b0; end
                1: begin cap = {16'd0, 32'($urandom_range(32'h1_0000, 32'h40_0000))}; ro = 1'b0; end
                2: begin cap = 48'd0;  ro = 1'b0; end
                3: begin cap = MAX48;  ro = 1'b1; end
                4: begin cap = {16'd0, 32'($urandom_range(0, 32'h10_0000))}; ro = coin(50); end
                default: begin cap = rand48(); ro = coin(50); end
            endcase
            apply_settings(cap, ro);
            // Hold the sink off once so that full backs up the sender.
            if (p == 1) rx_hold_req = LONG_HOLD_CYCLES;
            goal = live_beats + ITEMS_PER_SETTING;
            while (live_beats < goal) send_chain();
        end
        settle();

        $display("Run covered %0d descriptor beats under %0d register settings.",
                 live_beats, settings_used);
        $display("Checked %0d action beats, %0d closed chains; sender saw full %0d cycles.",
                 actions_seen, chains_closed, full_stalls);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop in case the block stops answering.
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Timeout: %0d action beats still owed", pending_actions.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
